>>> rtl/dte_pkg.sv
// shared types and constants for the dependency transition engine
// no dependencies, compiled first

package dte_pkg;

    localparam int POS_FIELD_W   = 7;
    localparam int LABEL_FIELD_W = 6;

    localparam logic [2:0] OP_SHIFT  = 3'd0;
    localparam logic [2:0] OP_LEFT   = 3'd1;
    localparam logic [2:0] OP_RIGHT  = 3'd2;
    localparam logic [2:0] OP_REDUCE = 3'd3;
    localparam logic [2:0] OP_BEGIN  = 3'd4;

    localparam logic SYS_STANDARD = 1'b0;
    localparam logic SYS_EAGER    = 1'b1;

    // register select on the config port
    localparam logic REG_SYSTEM     = 1'b0;
    localparam logic REG_WORD_COUNT = 1'b1;

    typedef struct packed {
        logic [2:0]               operation;
        logic [LABEL_FIELD_W-1:0] relation_type;
    } t_in_item;

    typedef struct packed {
        logic                     arc_made;
        logic [POS_FIELD_W-1:0]   dependent_word;
        logic [POS_FIELD_W-1:0]   head_word;
        logic [LABEL_FIELD_W-1:0] arc_label;
        logic [POS_FIELD_W-1:0]   stack_level;
        logic [POS_FIELD_W-1:0]   buffer_left;
        logic [POS_FIELD_W-1:0]   arcs_total;
    } t_out_item;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic capture;   // latch item, start stack read
        logic exec;      // apply transition, load result
    } t_cmd;

    typedef struct packed {
        logic out_free;  // result register can take a new result
    } t_stat;

endpackage

>>> rtl/dte_ctrl.sv
// controller state machine for the dependency transition engine
// depends on dte_pkg

module dte_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output dte_pkg::t_cmd  o_cmd,
    input  dte_pkg::t_stat i_stat
);

    dte_pkg::t_state r_state;
    dte_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dte_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dte_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = dte_pkg::ST_EXEC;
                end
            end
            dte_pkg::ST_EXEC: begin
                if (i_stat.out_free) begin
                    n_state = dte_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dte_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.exec    = 1'b0;
        unique case (r_state)
            dte_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            dte_pkg::ST_EXEC: begin
                o_cmd.exec = i_stat.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/dte_dp.sv
// datapath for the dependency transition engine: stack memory, top register,
// buffer pointer, arc counter and result register; depends on dte_pkg

module dte_dp #(
    parameter int MAX_WORDS  = 64,
    parameter int LABEL_BITS = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dte_pkg::t_cmd      i_cmd,
    output dte_pkg::t_stat     o_stat,
    input  dte_pkg::t_in_item  i_in_data,
    input  logic               i_transition_system,
    input  logic [6:0]         i_word_count,
    output logic               o_out_valid,
    output dte_pkg::t_out_item o_out_data,
    input  logic               i_out_ready
);

    // positions, counts and the arc total all stay within MAX_WORDS + 1
    localparam int PW = $clog2(MAX_WORDS + 2);
    // memory keeps the entries under the top: MAX_WORDS of them at most
    localparam int AW = $clog2(MAX_WORDS);
    localparam int LW = (LABEL_BITS < dte_pkg::LABEL_FIELD_W) ?
                        LABEL_BITS : dte_pkg::LABEL_FIELD_W;

    logic [PW-1:0] mem [MAX_WORDS];

    logic [2:0]    r_op;
    logic [LW-1:0] r_label;
    logic [PW-1:0] r_below;
    logic [PW-1:0] r_top;
    logic [PW-1:0] r_count;
    logic [PW-1:0] r_next;
    logic [PW-1:0] r_arcs;
    logic          r_out_valid;
    dte_pkg::t_out_item r_out;

    logic [PW-1:0] n_top;
    logic [PW-1:0] n_count;
    logic [PW-1:0] n_next;
    logic [PW-1:0] n_arcs;
    logic [PW-1:0] n_buf;
    logic [PW-1:0] lim;
    logic [PW-1:0] dep;
    logic [PW-1:0] head;
    logic          arc;
    logic          eager;
    logic          buf_ne;
    logic          can_push;
    logic          has_one;
    logic          has_two;
    logic          do_push;
    logic          do_pop;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

    // buffer end follows the register at once
    assign lim = (32'(i_word_count) > MAX_WORDS) ? PW'(MAX_WORDS) : PW'(i_word_count);
    assign eager    = (i_transition_system == dte_pkg::SYS_EAGER);
    assign buf_ne   = (r_next <= lim);
    assign has_one  = (r_count != '0);
    assign has_two  = (r_count > PW'(1));
    assign can_push = buf_ne && (r_count <= PW'(MAX_WORDS));

    // entry under the top sits at count - 2
    assign rd_addr = AW'(r_count - PW'(2));
    assign wr_addr = AW'(r_count - PW'(1));

    always_comb begin
        arc     = 1'b0;
        dep     = '0;
        head    = '0;
        do_push = 1'b0;
        do_pop  = 1'b0;
        unique case (r_op)
            dte_pkg::OP_SHIFT: begin
                do_push = can_push;
            end
            dte_pkg::OP_LEFT: begin
                if (!eager) begin
                    if (has_two) begin
                        // below is removed, top stays
                        arc  = 1'b1;
                        dep  = r_below;
                        head = r_top;
                    end
                end else if (has_one && buf_ne) begin
                    arc    = 1'b1;
                    dep    = r_top;
                    head   = r_next;
                    do_pop = 1'b1;
                end
            end
            dte_pkg::OP_RIGHT: begin
                if (!eager) begin
                    if (has_two) begin
                        arc    = 1'b1;
                        dep    = r_top;
                        head   = r_below;
                        do_pop = 1'b1;
                    end
                end else if (has_one && can_push) begin
                    arc     = 1'b1;
                    dep     = r_next;
                    head    = r_top;
                    do_push = 1'b1;
                end
            end
            dte_pkg::OP_REDUCE: begin
                do_pop = eager && has_one;
            end
            default: begin
                arc = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_top   = r_top;
        n_count = r_count;
        n_next  = r_next;
        n_arcs  = r_arcs;
        wr_en   = 1'b0;
        if (r_op == dte_pkg::OP_BEGIN) begin
            n_top   = '0;
            n_count = PW'(1);
            n_next  = PW'(1);
            n_arcs  = '0;
        end else begin
            if (do_push) begin
                wr_en   = i_cmd.exec && has_one;
                n_top   = r_next;
                n_count = r_count + PW'(1);
                n_next  = r_next + PW'(1);
            end else if (do_pop) begin
                n_top   = r_below;
                n_count = r_count - PW'(1);
            end else if (arc) begin
                // standard left arc: pop under the top
                n_count = r_count - PW'(1);
            end
            if (arc && (r_arcs < PW'(MAX_WORDS))) begin
                n_arcs = r_arcs + PW'(1);
            end
        end
        n_buf = (n_next <= lim) ? PW'(lim - n_next + PW'(1)) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= r_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_below <= mem[rd_addr];
            r_op    <= i_in_data.operation;
            r_label <= i_in_data.relation_type[LW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_next      <= PW'(1);
            r_arcs      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_count     <= n_count;
                r_next      <= n_next;
                r_arcs      <= n_arcs;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_top                <= n_top;
            r_out.arc_made       <= arc;
            r_out.dependent_word <= dte_pkg::POS_FIELD_W'(dep);
            r_out.head_word      <= dte_pkg::POS_FIELD_W'(head);
            r_out.arc_label      <= arc ? dte_pkg::LABEL_FIELD_W'(r_label) : '0;
            r_out.stack_level    <= dte_pkg::POS_FIELD_W'(n_count);
            r_out.buffer_left    <= dte_pkg::POS_FIELD_W'(n_buf);
            r_out.arcs_total     <= dte_pkg::POS_FIELD_W'(n_arcs);
        end
    end

endmodule

>>> rtl/dependency_transition_engine.sv
// a transfer is captured with the stack read, then applied once the result register is free
// takes a new transition only once the last is applied: the stack memory read for the entry
//   under the top is registered, and the next transition needs it before it can apply
// reset: synchronous, active low; clears config, stack count, arc count, sets next word to 1
//   the stack memory is not cleared, entries are written before they are read
module dependency_transition_engine #(
    parameter int MAX_WORDS  = 64,
    parameter int LABEL_BITS = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // item channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  dte_pkg::t_in_item  i_in_data,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output dte_pkg::t_out_item o_out_data,
    // config port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // config registers
    logic       r_transition_system;
    logic [6:0] r_word_count;
    logic       cfg_wr;

    dte_pkg::t_cmd  cmd;
    dte_pkg::t_stat stat;

    // port never waits
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // registers sit at byte offsets 0 and 4, select on the word bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_transition_system <= 1'b0;
            r_word_count        <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                dte_pkg::REG_SYSTEM:     r_transition_system <= pwdata[0];
                dte_pkg::REG_WORD_COUNT: r_word_count        <= pwdata[6:0];
                default:                 r_word_count        <= r_word_count;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (paddr[2])
            dte_pkg::REG_SYSTEM:     prdata = {31'd0, r_transition_system};
            dte_pkg::REG_WORD_COUNT: prdata = {25'd0, r_word_count};
            default:                 prdata = '0;
        endcase
    end

    // sequencer: idle -> exec, holds in exec while the result register is full and not taken
    dte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    // stack, buffer pointer, arc counter and result register
    dte_dp #(
        .MAX_WORDS  (MAX_WORDS),
        .LABEL_BITS (LABEL_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .i_in_data           (i_in_data),
        .i_transition_system (r_transition_system),
        .i_word_count        (r_word_count),
        .o_out_valid         (o_out_valid),
        .o_out_data          (o_out_data),
        .i_out_ready         (i_out_ready)
    );

    // one transition in flight: no transfer right after a transfer
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while a transition is in flight");

    // with an empty result register the result shows without a stall after the transfer
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !o_out_valid) |-> ##2 o_out_valid)
        else $error("result missing two cycles after transfer");

    // no arc means zero arc fields
    a_no_arc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.arc_made) |->
        (o_out_data.dependent_word == '0 && o_out_data.head_word == '0 &&
         o_out_data.arc_label == '0))
        else $error("arc fields set without an arc");

    // the memory read starts only on a transfer
    a_capture_on_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.capture |-> (i_in_valid && o_in_ready))
        else $error("capture without input transfer");

endmodule

>>> sim/dependency_transition_engine_tb.sv
`timescale 1ns / 1ps
// self-checking bench for dependency_transition_engine: directed and random transitions
// against an in-bench parser-state predictor; needs dte_pkg and the engine rtl

module dependency_transition_engine_tb;

    localparam int MAX_POS       = 64;
    localparam int STACK_SLOTS   = MAX_POS + 1;
    localparam int IDLE_LIMIT    = 2000;   // cycles with no transfer before giving up
    localparam int ITEM_TARGET   = 1900;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int REPORT_CAP    = 40;

    localparam logic [2:0] ADDR_SYSTEM     = {dte_pkg::REG_SYSTEM, 2'b00};
    localparam logic [2:0] ADDR_WORD_COUNT = {dte_pkg::REG_WORD_COUNT, 2'b00};

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    dte_pkg::t_in_item  i_in_data;
    logic               o_out_valid;
    logic               i_out_ready;
    dte_pkg::t_out_item o_out_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // parser state as the bench predicts it
    logic [6:0]  parse_stack [STACK_SLOTS];
    int          depth;
    int          next_pos;
    int          arc_count;
    bit          eager_rules;
    int          words_reg;

    dte_pkg::t_out_item step_outcomes_due [$];
    int          mismatch_count;
    int          items_sent;

    // knobs shared with the result sink
    bit          no_gaps;
    int          hold_len;
    bit          hold_toggle;

    dependency_transition_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // words still in the buffer; the end follows the register at once
    function automatic int buffer_words();
        int lim;
        lim = (words_reg > MAX_POS) ? MAX_POS : words_reg;
        return (next_pos <= lim) ? (lim - next_pos + 1) : 0;
    endfunction

    function automatic void push_next_word();
        if (buffer_words() > 0 && depth < STACK_SLOTS) begin
            parse_stack[depth] = 7'(next_pos);
            depth++;
            next_pos++;
        end
    endfunction

    function automatic dte_pkg::t_out_item apply_transition(input dte_pkg::t_in_item it);
        dte_pkg::t_out_item r;
        logic [2:0] op;
        logic [6:0] dep;
        logic [6:0] head;
        bit         arc;
        op   = it.operation;
        r    = '0;
        dep  = '0;
        head = '0;
        arc  = 1'b0;
        if (op == dte_pkg::OP_BEGIN) begin
            parse_stack[0] = '0;
            depth     = 1;
            next_pos  = 1;
            arc_count = 0;
        end else if (op == dte_pkg::OP_SHIFT) begin
            push_next_word();
        end else if (!eager_rules) begin
            // arc-standard: both arcs work on the top two entries, reduce is ignored
            if ((op == dte_pkg::OP_LEFT || op == dte_pkg::OP_RIGHT) && depth > 1) begin
                if (op == dte_pkg::OP_LEFT) begin
                    dep  = parse_stack[depth-2];
                    head = parse_stack[depth-1];
                    parse_stack[depth-2] = head;
                end else begin
                    dep  = parse_stack[depth-1];
                    head = parse_stack[depth-2];
                end
                depth--;
                arc = 1'b1;
            end
        end else if (op == dte_pkg::OP_LEFT) begin
            // arc-eager left: top hangs off the first buffer word
            if (depth > 0 && buffer_words() > 0) begin
                dep  = parse_stack[depth-1];
                head = 7'(next_pos);
                depth--;
                arc = 1'b1;
            end
        end else if (op == dte_pkg::OP_RIGHT) begin
            // arc-eager right: first buffer word hangs off the top and is shifted
            if (depth > 0 && buffer_words() > 0 && depth < STACK_SLOTS) begin
                head = parse_stack[depth-1];
                dep  = 7'(next_pos);
                push_next_word();
                arc = 1'b1;
            end
        end else if (op == dte_pkg::OP_REDUCE) begin
            if (depth > 0)
                depth--;
        end
        if (arc && arc_count < MAX_POS)
            arc_count++;
        r.arc_made       = arc;
        r.dependent_word = dep;
        r.head_word      = head;
        r.arc_label      = arc ? it.relation_type : '0;
        r.stack_level    = 7'(depth);
        r.buffer_left    = 7'(buffer_words());
        r.arcs_total     = 7'(arc_count);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < REPORT_CAP)
            $display("%0t mismatch: %s got %0h want %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // every result transfer is matched against the oldest prediction
    always @(posedge i_clk) begin : result_check
        dte_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (step_outcomes_due.size() == 0) begin
                report_mismatch("result with nothing outstanding", 64'(o_out_data), '0);
            end else begin
                want = step_outcomes_due.pop_front();
                check_field("arc_made", 64'(o_out_data.arc_made), 64'(want.arc_made));
                check_field("dependent_word", 64'(o_out_data.dependent_word),
                            64'(want.dependent_word));
                check_field("head_word", 64'(o_out_data.head_word), 64'(want.head_word));
                check_field("arc_label", 64'(o_out_data.arc_label), 64'(want.arc_label));
                check_field("stack_level", 64'(o_out_data.stack_level),
                            64'(want.stack_level));
                check_field("buffer_left", 64'(o_out_data.buffer_left),
                            64'(want.buffer_left));
                check_field("arcs_total", 64'(o_out_data.arcs_total), 64'(want.arcs_total));
            end
        end
    end

    // any transfer on any port restarts the count
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // mostly no gap, some short, a few long
    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: random stalls plus a long hold-off when the toggle flips
    initial begin : result_sink
        int stall_left;
        int hold_left;
        bit seen_toggle;
        stall_left  = 0;
        hold_left   = 0;
        seen_toggle = 1'b0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_toggle != seen_toggle) begin
                seen_toggle = hold_toggle;
                hold_left   = hold_len;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                stall_left = no_gaps ? 0 : random_gap();
            end
        end
    end

    task automatic sender_gap(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
    endtask

    // one transition transfer; valid stays up so the next one can follow directly
    task automatic send_transition(input logic [2:0] op, input logic [5:0] label);
        dte_pkg::t_in_item it;
        it.operation     = op;
        it.relation_type = label;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        step_outcomes_due.push_back(apply_transition(it));
        items_sent++;
    endtask

    task automatic send_paced(input logic [2:0] op, input logic [5:0] label);
        send_transition(op, label);
        if (!no_gaps)
            sender_gap(random_gap());
    endtask

    task automatic wait_for_results();
        sender_gap(1);
        while (step_outcomes_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_SYSTEM)
            eager_rules = value[0];
        else
            words_reg = int'(value[6:0]);
    endtask

    task automatic read_register(input logic [2:0] addr, output logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        value = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // only while idle: drain, then write both registers and read them back
    task automatic configure(input logic system, input int words);
        logic [31:0] readback;
        wait_for_results();
        write_register(ADDR_SYSTEM, 32'(system));
        write_register(ADDR_WORD_COUNT, 32'(words));
        read_register(ADDR_SYSTEM, readback);
        check_field("transition_system readback", 64'(readback), 64'(system));
        read_register(ADDR_WORD_COUNT, readback);
        check_field("word_count readback", 64'(readback), 64'(words));
    endtask

    // mostly a transition whose preconditions hold, sometimes any code at all
    function automatic logic [2:0] pick_transition();
        logic [2:0] legal [$];
        int         avail;
        if ($urandom_range(0, 99) < 12)
            return 3'($urandom_range(0, 7));
        avail = buffer_words();
        if (avail > 0 && depth < STACK_SLOTS)
            legal.push_back(dte_pkg::OP_SHIFT);
        if (eager_rules) begin
            if (depth > 0 && avail > 0) begin
                legal.push_back(dte_pkg::OP_LEFT);
                legal.push_back(dte_pkg::OP_RIGHT);
            end
            if (depth > 0)
                legal.push_back(dte_pkg::OP_REDUCE);
        end else if (depth > 1) begin
            legal.push_back(dte_pkg::OP_LEFT);
            legal.push_back(dte_pkg::OP_RIGHT);
        end
        if (legal.size() == 0)
            return 3'($urandom_range(0, 7));
        return legal[$urandom_range(0, legal.size() - 1)];
    endfunction

    function automatic bit sentence_done();
        return buffer_words() == 0 && (eager_rules || depth <= 1);
    endfunction

    // mostly small sentences, now and then none, the largest or an oversized count
    function automatic int pick_word_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 0;
        if (r < 15)
            return MAX_POS;
        if (r < 21)
            return $urandom_range(MAX_POS + 1, 127);
        return $urandom_range(1, 12);
    endfunction

    task automatic run_sentence(input bit fresh);
        int steps;
        int limit;
        if (fresh)
            send_paced(dte_pkg::OP_BEGIN, 6'($urandom));
        limit = 4 * ((words_reg > MAX_POS) ? MAX_POS : words_reg) + 10;
        steps = 0;
        while (steps < limit && !sentence_done()) begin
            send_paced(pick_transition(), 6'($urandom));
            steps++;
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset state: empty stack, no root, word count zero; then shifts and arcs on two words without a begin
    task automatic test_before_begin();
        send_paced(dte_pkg::OP_SHIFT, 6'd5);
        send_paced(dte_pkg::OP_LEFT, 6'd9);
        send_paced(dte_pkg::OP_REDUCE, 6'd0);
        send_paced(3'd7, 6'd63);
        configure(dte_pkg::SYS_STANDARD, 2);
        send_paced(dte_pkg::OP_SHIFT, 6'd0);
        send_paced(dte_pkg::OP_SHIFT, 6'd0);
        send_paced(dte_pkg::OP_RIGHT, 6'd63);
        send_paced(dte_pkg::OP_LEFT, 6'd1);
    endtask

    task automatic test_standard_rules();
        configure(dte_pkg::SYS_STANDARD, 3);
        send_paced(dte_pkg::OP_BEGIN, 6'd63);     // label must not show without an arc
        send_paced(dte_pkg::OP_LEFT, 6'd7);       // only root on the stack
        send_paced(dte_pkg::OP_SHIFT, 6'd0);
        send_paced(dte_pkg::OP_SHIFT, 6'd0);
        send_paced(dte_pkg::OP_LEFT, 6'd42);
        send_paced(dte_pkg::OP_SHIFT, 6'd0);
        send_paced(dte_pkg::OP_RIGHT, 6'd1);
        send_paced(dte_pkg::OP_RIGHT, 6'd63);     // remaining word attaches to root
        send_paced(dte_pkg::OP_RIGHT, 6'd2);      // root alone, nothing happens
        send_paced(dte_pkg::OP_REDUCE, 6'd3);     // ignored under arc-standard
        send_paced(3'd6, 6'd4);
        send_paced(dte_pkg::OP_SHIFT, 6'd0);      // buffer empty
    endtask

    task automatic test_eager_rules();
        configure(dte_pkg::SYS_EAGER, 127);       // oversized count acts as the maximum
        send_paced(dte_pkg::OP_BEGIN, 6'd0);
        send_paced(dte_pkg::OP_RIGHT, 6'd63);
        send_paced(dte_pkg::OP_LEFT, 6'd21);
        send_paced(dte_pkg::OP_REDUCE, 6'd0);     // pops root
        send_paced(dte_pkg::OP_LEFT, 6'd11);      // empty stack
        send_paced(dte_pkg::OP_RIGHT, 6'd12);
        send_paced(dte_pkg::OP_REDUCE, 6'd0);
        send_paced(dte_pkg::OP_SHIFT, 6'd0);
        send_paced(3'd5, 6'd63);
        send_paced(3'd7, 6'd0);
        // shrink the sentence under the next word: buffer reads empty
        configure(dte_pkg::SYS_EAGER, 1);
        send_paced(dte_pkg::OP_SHIFT, 6'd0);
        send_paced(dte_pkg::OP_RIGHT, 6'd30);
        send_paced(dte_pkg::OP_LEFT, 6'd31);
    endtask

    // eager right arcs then left arcs give more arcs than words
    task automatic test_arc_count_saturation();
        configure(dte_pkg::SYS_EAGER, MAX_POS);
        send_paced(dte_pkg::OP_BEGIN, 6'($urandom));
        repeat (MAX_POS - 1) send_paced(dte_pkg::OP_RIGHT, 6'($urandom));
        repeat (MAX_POS + 1) send_paced(dte_pkg::OP_LEFT, 6'($urandom));
    endtask

    // result side holds off while items keep coming, then the sender waits for all
    task automatic test_backpressure();
        configure(dte_pkg::SYS_STANDARD, 20);
        hold_len    = HOLD_CYCLES;
        hold_toggle = ~hold_toggle;
        send_transition(dte_pkg::OP_BEGIN, 6'd0);
        repeat (40) send_transition(pick_transition(), 6'($urandom));
        wait_for_results();
    endtask

    task automatic test_random_sentences();
        int sentences;
        bit fresh;
        while (items_sent < ITEM_TARGET) begin
            configure(1'($urandom_range(0, 1)), pick_word_count());
            no_gaps   = ($urandom_range(0, 4) == 0);
            sentences = $urandom_range(1, 4);
            // sometimes carry the old sentence over into the new settings
            fresh = ($urandom_range(0, 3) != 0);
            repeat (sentences) begin
                run_sentence(fresh);
                fresh = 1'b1;
            end
        end
        no_gaps = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        no_gaps     = 1'b0;
        hold_len    = 0;
        hold_toggle = 1'b0;
        mismatch_count = 0;
        items_sent  = 0;
        // predicted state after reset
        depth       = 0;
        next_pos    = 1;
        arc_count   = 0;
        eager_rules = 1'b0;
        words_reg   = 0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_before_begin();
        test_standard_rules();
        test_eager_rules();
        test_arc_count_saturation();
        test_backpressure();
        test_random_sentences();
        wait_for_results();

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
